[rtl/escaped_frame_deframer_assert.svh]
// Assertion macros for the escaped frame deframer.
`ifndef ESCAPED_FRAME_DEFRAMER_ASSERT_SVH
`define ESCAPED_FRAME_DEFRAMER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define EFD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define EFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

[rtl/efd_pkg.sv]
// Shared types and constants of the escaped frame deframer.
package efd_pkg;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [PADDR_W-1:0] ADDR_START_BYTE  = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_ESCAPE_BYTE = 4'h4;
  localparam logic [PADDR_W-1:0] ADDR_MAX_PAYLOAD = 4'h8;

  localparam logic [7:0]  RST_START_BYTE  = 8'h7E;
  localparam logic [7:0]  RST_ESCAPE_BYTE = 8'h7D;
  localparam logic [15:0] RST_MAX_PAYLOAD = 16'd256;

  localparam logic [7:0] ESC_XOR  = 8'h20;
  localparam logic [7:0] SUM_GOOD = 8'hFF;

  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_GOOD      = 3'd1;
  localparam logic [2:0] KIND_BADSUM    = 3'd2;
  localparam logic [2:0] KIND_LENERR    = 3'd3;
  localparam logic [2:0] KIND_MALFORMED = 3'd4;

  typedef enum logic [4:0] {
    PH_HUNT    = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_LEN_LO  = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CHECK   = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] raw_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [2:0]  out_kind;
    logic [15:0] frame_length;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  escape_byte;
    logic [15:0] max_payload;
  } cfg_t;

endpackage

[rtl/efd_cfg.sv]
// Configuration register file of the escaped frame deframer.
module efd_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efd_pkg::PADDR_W-1:0]  paddr,
  input  logic [efd_pkg::PDATA_W-1:0]  pwdata,
  output logic [efd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output efd_pkg::cfg_t                cfg
);
  import efd_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte  <= RST_START_BYTE;
      cfg_r.escape_byte <= RST_ESCAPE_BYTE;
      cfg_r.max_payload <= RST_MAX_PAYLOAD;
    end else if (wr_en) begin
      case (paddr)
        ADDR_START_BYTE:  cfg_r.start_byte  <= pwdata[7:0];
        ADDR_ESCAPE_BYTE: cfg_r.escape_byte <= pwdata[7:0];
        ADDR_MAX_PAYLOAD: cfg_r.max_payload <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ADDR_START_BYTE:  prdata = {24'd0, cfg_r.start_byte};
      ADDR_ESCAPE_BYTE: prdata = {24'd0, cfg_r.escape_byte};
      ADDR_MAX_PAYLOAD: prdata = {16'd0, cfg_r.max_payload};
      default:          prdata = '0;
    endcase
  end

endmodule

[rtl/efd_parse.sv]
// Frame parser state machine that turns one byte into at most one result.
module efd_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  efd_pkg::cfg_t       cfg,
  input  logic                en,
  input  efd_pkg::in_item_t   item,
  output logic                res_vld,
  output efd_pkg::out_item_t  res
);
  import efd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        esc_r, esc_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] decl_r, decl_nxt;
  logic [15:0] seen_r, seen_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        start_seen_r, start_seen_nxt;

  always_comb begin
    logic [7:0] b;
    logic [7:0] v;
    logic       vr;
    logic       last;
    b              = item.raw_byte;
    last           = item.buffer_end;
    v              = '0;
    vr             = 1'b0;
    phase_nxt      = phase_r;
    esc_nxt        = esc_r;
    len_hi_nxt     = len_hi_r;
    decl_nxt       = decl_r;
    seen_nxt       = seen_r;
    sum_nxt        = sum_r;
    start_seen_nxt = start_seen_r;
    res_vld        = 1'b0;
    res            = '0;
    if (en) begin
      case (phase_r)
        PH_HUNT: begin
          if (b == cfg.start_byte) begin
            start_seen_nxt = 1'b1;
            phase_nxt      = PH_LEN_HI;
            esc_nxt        = 1'b0;
            len_hi_nxt     = '0;
            decl_nxt       = '0;
            seen_nxt       = '0;
            sum_nxt        = '0;
          end
        end
        PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD: begin
          if (esc_r) begin
            v       = b ^ ESC_XOR;
            esc_nxt = 1'b0;
            vr      = 1'b1;
          end else if (b == cfg.escape_byte) begin
            esc_nxt = 1'b1;
          end else begin
            v  = b;
            vr = 1'b1;
          end
          if (vr) begin
            if (phase_r == PH_LEN_HI) begin
              len_hi_nxt = v;
              phase_nxt  = PH_LEN_LO;
            end else if (phase_r == PH_LEN_LO) begin
              decl_nxt = {len_hi_r, v};
              if (decl_nxt > cfg.max_payload) begin
                res_vld          = 1'b1;
                res.out_kind     = KIND_LENERR;
                res.frame_length = decl_nxt;
                phase_nxt        = PH_HUNT;
                esc_nxt          = 1'b0;
              end else if (decl_nxt == '0) begin
                phase_nxt = PH_CHECK;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              sum_nxt  = sum_r + v;
              seen_nxt = seen_r + 16'd1;
              if (seen_nxt >= decl_r) begin
                phase_nxt = PH_CHECK;
              end
              if (!last) begin
                res_vld          = 1'b1;
                res.out_byte     = v;
                res.out_kind     = KIND_DATA;
                res.frame_length = decl_r;
              end
            end
          end
        end
        PH_CHECK: begin
          res_vld          = 1'b1;
          res.out_kind     = (8'(sum_r + b) == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM;
          res.frame_length = decl_r;
          phase_nxt        = PH_HUNT;
          esc_nxt          = 1'b0;
        end
        default: begin
          phase_nxt = PH_HUNT;
          esc_nxt   = 1'b0;
        end
      endcase
      if (last) begin
        if (!res_vld) begin
          if (phase_nxt != PH_HUNT) begin
            res_vld          = 1'b1;
            res.out_kind     = KIND_LENERR;
            res.frame_length = decl_nxt;
          end else if (!start_seen_nxt) begin
            res_vld      = 1'b1;
            res.out_kind = KIND_MALFORMED;
          end
        end
        phase_nxt      = PH_HUNT;
        esc_nxt        = 1'b0;
        start_seen_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      esc_r        <= 1'b0;
      len_hi_r     <= '0;
      decl_r       <= '0;
      seen_r       <= '0;
      sum_r        <= '0;
      start_seen_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      esc_r        <= esc_nxt;
      len_hi_r     <= len_hi_nxt;
      decl_r       <= decl_nxt;
      seen_r       <= seen_nxt;
      sum_r        <= sum_nxt;
      start_seen_r <= start_seen_nxt;
    end
  end

endmodule

[rtl/escaped_frame_deframer.sv]
// Top level of the escaped frame deframer with input and result registers.
// The block takes one received byte per request on the in_ channel, with a
// flag that marks the last byte of a buffer. It strips the framing: it hunts
// for the start byte, reads a two-byte big-endian length, passes each
// unescaped payload byte that does not end the buffer out as a request on the
// out_ channel, and closes the frame with a status request that reports a good
// or bad checksum. Length errors and buffers with no start byte give error requests.
// The user must write the configuration registers over the APB-style port
// only while the block is idle; the block itself does not enforce this.
// An accepted byte passes the input register and the parser and lands in the
// result register when that register is free; the receiver takes it there.
// One byte is accepted per cycle as long as the receiver takes results; the
// parser state is registered once per accepted byte, which sets this rate.
// Reset returns the parser to hunting and the registers to their defaults.
// When the receiver stalls, the result register holds its request, the
// input register fills, and in_ready falls until the result is taken.
module escaped_frame_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  efd_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output efd_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [efd_pkg::PADDR_W-1:0]  paddr,
  input  logic [efd_pkg::PDATA_W-1:0]  pwdata,
  output logic [efd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import efd_pkg::*;

  cfg_t      cfg;
  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r;
  logic      adv;
  logic      proc;
  logic      res_vld;
  out_item_t res;

  efd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  efd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .en      (proc),
    .item    (in_item_r),
    .res_vld (res_vld),
    .res     (res)
  );

  assign adv       = !out_vld_r || out_ready;
  assign proc      = in_vld_r && adv;
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

  assign in_vld_nxt  = in_ready ? in_valid : in_vld_r;
  assign out_vld_nxt = adv ? (proc && res_vld) : out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (proc && res_vld) begin
      out_item_r <= res;
    end
  end

`include "escaped_frame_deframer_assert.svh"

  `EFD_ASSERT_NOW(a_stall_full, !in_ready, in_vld_r && out_vld_r && !out_ready)
  `EFD_ASSERT_NOW(a_status_no_byte, out_vld_r && (out_data.out_kind != KIND_DATA), out_data.out_byte == 8'd0)
  `EFD_ASSERT_NOW(a_malformed_len, out_vld_r && (out_data.out_kind == KIND_MALFORMED), out_data.frame_length == 16'd0)
  `EFD_ASSERT_NEXT(a_result_source, !out_vld_r, !out_vld_r || $past(in_vld_r))

endmodule

[test/testbench.sv]
// Self-checking testbench for the escaped frame deframer, with its own model of the parser.
module testbench;
  import efd_pkg::*;

  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  cfg_t regs;
  phase_t ph;
  logic esc_armed;
  logic [7:0] len_hi;
  logic [15:0] decl_len;
  logic [15:0] n_payload;
  logic [7:0] sum_acc;
  logic saw_start;

  out_item_t expected_q[$];
  logic [7:0] frame_q[$];
  int n_fail = 0;
  int n_sent = 0;
  int idle_cycles = 0;
  int rx_hold = 0;
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;

  escaped_frame_deframer i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t make_result(input logic [7:0] b, input logic [2:0] kind,
                                            input logic [15:0] len);
    return {b, kind, len};
  endfunction

  function automatic void model_reset();
    regs = {RST_START_BYTE, RST_ESCAPE_BYTE, RST_MAX_PAYLOAD};
    ph = PH_HUNT;
    esc_armed = 1'b0;
    len_hi = '0;
    decl_len = '0;
    n_payload = '0;
    sum_acc = '0;
    saw_start = 1'b0;
  endfunction

  function automatic bit deframe_byte(input in_item_t item, output out_item_t res);
    logic [7:0] val;
    logic [7:0] total;
    bit got;
    bit have;
    val = '0;
    got = 1'b0;
    have = 1'b0;
    res = '0;
    case (ph)
      PH_HUNT: begin
        if (item.raw_byte == regs.start_byte) begin
          saw_start = 1'b1;
          ph = PH_LEN_HI;
          esc_armed = 1'b0;
          len_hi = '0;
          decl_len = '0;
          n_payload = '0;
          sum_acc = '0;
        end
      end
      PH_LEN_HI, PH_LEN_LO, PH_PAYLOAD: begin
        if (esc_armed) begin
          val = item.raw_byte ^ ESC_XOR;
          esc_armed = 1'b0;
          got = 1'b1;
        end else if (item.raw_byte == regs.escape_byte) begin
          esc_armed = 1'b1;
        end else begin
          val = item.raw_byte;
          got = 1'b1;
        end
        if (got) begin
          if (ph == PH_LEN_HI) begin
            len_hi = val;
            ph = PH_LEN_LO;
          end else if (ph == PH_LEN_LO) begin
            decl_len = {len_hi, val};
            if (decl_len > regs.max_payload) begin
              res = make_result(8'h00, KIND_LENERR, decl_len);
              have = 1'b1;
              ph = PH_HUNT;
              esc_armed = 1'b0;
            end else if (decl_len == 16'd0) begin
              ph = PH_CHECK;
            end else begin
              ph = PH_PAYLOAD;
            end
          end else begin
            sum_acc = sum_acc + val;
            n_payload = n_payload + 16'd1;
            if (n_payload >= decl_len) ph = PH_CHECK;
            if (!item.buffer_end) begin
              res = make_result(val, KIND_DATA, decl_len);
              have = 1'b1;
            end
          end
        end
      end
      PH_CHECK: begin
        total = sum_acc + item.raw_byte;
        res = make_result(8'h00, (total == SUM_GOOD) ? KIND_GOOD : KIND_BADSUM, decl_len);
        have = 1'b1;
        ph = PH_HUNT;
        esc_armed = 1'b0;
      end
      default: begin
        ph = PH_HUNT;
        esc_armed = 1'b0;
      end
    endcase
    if (item.buffer_end) begin
      if (!have) begin
        if (ph != PH_HUNT) begin
          res = make_result(8'h00, KIND_LENERR, decl_len);
          have = 1'b1;
        end else if (!saw_start) begin
          res = make_result(8'h00, KIND_MALFORMED, 16'd0);
          have = 1'b1;
        end
      end
      ph = PH_HUNT;
      esc_armed = 1'b0;
      saw_start = 1'b0;
    end
    return have;
  endfunction

  task automatic flag_mismatch(input string field, input int want, input int got);
    n_fail++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : check_proc
    out_item_t want;
    out_item_t got;
    if (rst_n && in_valid && in_ready) begin
      if (deframe_byte(in_data, want)) expected_q.push_back(want);
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (expected_q.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected request, expected none, actual %h", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
          flag_mismatch("out_byte", int'(want.out_byte), int'(got.out_byte));
        if (got.out_kind !== want.out_kind)
          flag_mismatch("out_kind", int'(want.out_kind), int'(got.out_kind));
        if (got.frame_length !== want.frame_length)
          flag_mismatch("frame_length", int'(want.frame_length), int'(got.frame_length));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("[escaped_frame_deframer] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : receiver
    int stall;
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = rx_calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && rx_hold == 0) @(posedge clk);
    end
  end

  task automatic push_byte(input logic [7:0] raw, input logic last);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= {raw, last};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic write_cfg(input cfg_t c);
    write_reg(ADDR_START_BYTE, {24'd0, c.start_byte});
    write_reg(ADDR_ESCAPE_BYTE, {24'd0, c.escape_byte});
    write_reg(ADDR_MAX_PAYLOAD, {16'd0, c.max_payload});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    regs = c;
  endtask

  function automatic void stuff_byte(input logic [7:0] v);
    if (v == regs.escape_byte || v == regs.start_byte || $urandom_range(0, 7) == 0) begin
      frame_q.push_back(regs.escape_byte);
      frame_q.push_back(v ^ ESC_XOR);
    end else begin
      frame_q.push_back(v);
    end
  endfunction

  task automatic send_frame(input logic [15:0] len, input bit good, input bit cut_short,
                            input bit end_on_chk);
    logic [7:0] v;
    logic [7:0] sum;
    logic [7:0] chk;
    int stop;
    int i;
    frame_q.delete();
    frame_q.push_back(regs.start_byte);
    stuff_byte(len[15:8]);
    stuff_byte(len[7:0]);
    sum = '0;
    if (len <= regs.max_payload) begin
      for (i = 0; i < len; i++) begin
        v = 8'($urandom);
        sum = sum + v;
        stuff_byte(v);
      end
      chk = SUM_GOOD - sum;
      if (!good) chk = chk ^ 8'($urandom_range(1, 255));
      frame_q.push_back(chk);
    end
    stop = cut_short ? $urandom_range(0, frame_q.size() - 1) : frame_q.size() - 1;
    for (i = 0; i <= stop; i++)
      push_byte(frame_q[i], (i == stop) && (cut_short || end_on_chk));
  endtask

  task automatic send_unit();
    int pick;
    int cap;
    logic [15:0] len;
    pick = $urandom_range(0, 99);
    tx_calm = ($urandom_range(0, 4) == 0);
    rx_calm = ($urandom_range(0, 4) == 0);
    cap = (regs.max_payload < 16'd12) ? int'(regs.max_payload) : 12;
    len = 16'($urandom_range(0, cap));
    if (pick < 60) begin
      send_frame(len, $urandom_range(0, 3) != 0, 1'b0, $urandom_range(0, 5) == 0);
    end else if (pick < 72 && regs.max_payload != 16'hFFFF) begin
      send_frame(16'($urandom_range(int'(regs.max_payload) + 1, 65535)), 1'b1, 1'b0, 1'b0);
    end else if (pick < 86) begin
      send_frame(len, 1'b1, 1'b1, 1'b0);
    end else begin
      push_byte(8'($urandom), $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic test_directed_frames();
    push_byte(8'h00, 1'b1);
    push_byte(8'h7E, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h7D, 1'b0); push_byte(8'h5D, 1'b0); push_byte(8'h82, 1'b0);
    push_byte(8'h7E, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h7E, 1'b0); push_byte(8'h7D, 1'b1);
    push_byte(8'h7E, 1'b0); push_byte(8'h7D, 1'b0); push_byte(8'h21, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h7E, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h02, 1'b0);
    push_byte(8'hAA, 1'b1);
    push_byte(8'h7E, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'h33, 1'b1);
    push_byte(8'h7E, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h7D, 1'b1);
    drain_results();
  endtask

  task automatic test_receiver_stall();
    tx_calm = 1'b1;
    rx_calm = 1'b0;
    rx_hold = 100;
    send_frame(16'd30, 1'b1, 1'b0, 1'b0);
    drain_results();
    tx_calm = 1'b0;
  endtask

  task automatic test_register_extremes();
    write_cfg({8'h00, 8'hFF, 16'd0});
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hDF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAB, 1'b1);
    push_byte(8'hAB, 1'b1);
    drain_results();
    write_cfg({8'hFF, 8'h00, 16'hFFFF});
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b1);
    send_frame(16'd5, 1'b1, 1'b0, 1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic();
    cfg_t c;
    int step;
    int quota;
    for (step = 0; step < 6; step++) begin
      c.start_byte = 8'($urandom);
      if (step == 5) begin
        c.escape_byte = c.start_byte;
      end else begin
        do c.escape_byte = 8'($urandom); while (c.escape_byte == c.start_byte);
      end
      case (step % 4)
        0: c.max_payload = 16'($urandom_range(0, 24));
        1: c.max_payload = 16'hFFFF;
        2: c.max_payload = RST_MAX_PAYLOAD;
        default: c.max_payload = 16'($urandom_range(0, 3));
      endcase
      write_cfg(c);
      quota = n_sent + 95;
      while (n_sent < quota) send_unit();
      drain_results();
    end
  endtask

  initial begin
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_receiver_stall();
    test_register_extremes();
    test_random_traffic();
    drain_results();
    if (expected_q.size() != 0) begin
      n_fail++;
      $display("%0t: %0d expected requests never arrived", $time, expected_q.size());
    end
    if (n_fail == 0) $display("[escaped_frame_deframer] OK");
    else $display("[escaped_frame_deframer] ERROR");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/efd_pkg.sv
rtl/efd_cfg.sv
rtl/efd_parse.sv
rtl/escaped_frame_deframer.sv
test/testbench.sv
